// ----- hdl/tfpg_pkg.sv -----
`timescale 1ns / 1ps

package tfpg_pkg;

  localparam int NUM_CHAN        = 6;
  localparam int REG_W           = 16;
  localparam int CFG_INDEX_W     = 2;
  localparam int START_W         = 5;
  localparam int START_EVENTS_DEF = 30;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRE_DELAY  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WIDTH = CFG_INDEX_W'(1);

  // low gates of phases U and W
  localparam logic [NUM_CHAN-1:0] BRAKE_LOW_MASK = 6'b100010;

  typedef struct packed {
    logic step;
    logic arm;
    logic started;
    logic clr_arm;
    logic brake_cut;
  } chan_ctrl_t;

  typedef struct packed {
    logic armed;
    logic firing;
    logic gate_on;
  } chan_stat_t;

endpackage

// ----- hdl/tfpg_in_if.sv -----
`timescale 1ns / 1ps

interface tfpg_in_if;
  import tfpg_pkg::*;

  logic                valid;
  logic                ready;
  logic [NUM_CHAN-1:0] arm_mask;
  logic                brake;

  modport source (output valid, output arm_mask, output brake, input ready);
  modport sink   (input valid, input arm_mask, input brake, output ready);
endinterface

// ----- hdl/tfpg_out_if.sv -----
`timescale 1ns / 1ps

interface tfpg_out_if;
  import tfpg_pkg::*;

  logic                valid;
  logic                ready;
  logic [NUM_CHAN-1:0] gate_mask;
  logic                running;

  modport source (output valid, output gate_mask, output running, input ready);
  modport sink   (input valid, input gate_mask, input running, output ready);
endinterface

// ----- hdl/tfpg_cfg_if.sv -----
`timescale 1ns / 1ps

interface tfpg_cfg_if;
  import tfpg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [REG_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/thyristor_firing_pulse_gen.sv -----
`timescale 1ns / 1ps

// Six-gate phase-angle firing unit. Each input item is one timer tick; it is
// held in an input register and, once the output register can take a result, updates the startup counter
// and the six channel counters in a single pass. The result item is the gate
// state after that tick and is presented on out_chan from the registers written in that pass.
// One item is taken every clock cycle; the input stalls only when both the
// input register and the result are waiting on out_chan.ready. Configuration
// writes are always accepted and take effect on the next tick.
module thyristor_firing_pulse_gen #(
  parameter int START_EVENTS = tfpg_pkg::START_EVENTS_DEF,
  parameter int COUNT_WIDTH  = tfpg_pkg::COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tfpg_in_if.sink    in_chan,
  tfpg_out_if.source out_chan,
  tfpg_cfg_if.sink   cfg_chan
);
  import tfpg_pkg::*;

  logic                s1_valid_r, s1_valid_nxt;
  logic [NUM_CHAN-1:0] s1_arm_r;
  logic                s1_brake_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load, step, in_ready, arm0;

  logic [REG_W-1:0]    fire_delay_r, pulse_width_r;

  logic                started_r, started_nxt;
  logic [START_W-1:0]  start_cnt_r, start_cnt_nxt;
  logic [START_W:0]    start_inc;

  chan_ctrl_t          ctrl [NUM_CHAN];
  chan_stat_t          stat [NUM_CHAN];
  logic [NUM_CHAN-1:0] gate_vec, firing_vec;

  assign out_load      = ~out_valid_r | out_chan.ready;
  assign step          = s1_valid_r & out_load;
  assign in_ready      = ~s1_valid_r | step;
  assign in_chan.ready = in_ready;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_chan.valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) begin
      s1_arm_r   <= in_chan.arm_mask;
      s1_brake_r <= in_chan.brake;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_delay_r  <= '0;
      pulse_width_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_FIRE_DELAY:  fire_delay_r  <= cfg_chan.data;
        REG_PULSE_WIDTH: pulse_width_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign arm0      = stat[0].armed | s1_arm_r[0];
  assign start_inc = {1'b0, start_cnt_r} + (START_W+1)'(1);

  always_comb begin
    started_nxt   = started_r;
    start_cnt_nxt = start_cnt_r;
    if (!started_r && arm0) begin
      if (start_inc > (START_W+1)'(START_EVENTS)) begin
        started_nxt   = 1'b1;
        start_cnt_nxt = '0;
      end else begin
        start_cnt_nxt = start_inc[START_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      start_cnt_r <= '0;
    end else if (step) begin
      started_r   <= started_nxt;
      start_cnt_r <= start_cnt_nxt;
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    assign ctrl[c].step      = step;
    assign ctrl[c].arm       = s1_arm_r[c];
    assign ctrl[c].started   = started_r;
    assign ctrl[c].clr_arm   = arm0;
    assign ctrl[c].brake_cut = s1_brake_r & BRAKE_LOW_MASK[c];

    tfpg_chan #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_chan (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl[c]),
      .fire_delay  (fire_delay_r),
      .pulse_width (pulse_width_r),
      .stat        (stat[c])
    );

    assign gate_vec[c]   = stat[c].gate_on;
    assign firing_vec[c] = stat[c].firing;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.gate_mask = gate_vec;
  assign out_chan.running   = started_r;

  a_gates_off_in_startup: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> gate_vec == '0)
    else $error("gate driven before startup completed");

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("running dropped");

  a_gate_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (gate_vec & ~firing_vec) == '0)
    else $error("gate on outside a firing pulse");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_chan.ready)
    else $error("input stalled without a full pipeline");

endmodule

// ----- hdl/tfpg_chan.sv -----
`timescale 1ns / 1ps

module tfpg_chan #(
  parameter int COUNT_WIDTH = tfpg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tfpg_pkg::chan_ctrl_t         ctrl,
  input  logic [tfpg_pkg::REG_W-1:0]   fire_delay,
  input  logic [tfpg_pkg::REG_W-1:0]   pulse_width,
  output tfpg_pkg::chan_stat_t         stat
);
  import tfpg_pkg::*;

  localparam int CMP_W = ((COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W) + 1;

  logic                   armed_r, armed_nxt, armed_m;
  logic                   firing_r, firing_nxt;
  logic                   gate_r, gate_nxt;
  logic [COUNT_WIDTH-1:0] delay_r, delay_nxt;
  logic [COUNT_WIDTH-1:0] pulse_r, pulse_nxt;
  logic [CMP_W-1:0]       dly_inc;
  logic [CMP_W-1:0]       pls_inc;

  always_comb begin
    armed_m    = armed_r | ctrl.arm;
    armed_nxt  = armed_m;
    firing_nxt = firing_r;
    gate_nxt   = gate_r;
    delay_nxt  = delay_r;
    pulse_nxt  = pulse_r;
    dly_inc    = CMP_W'(delay_r) + CMP_W'(1);
    pls_inc    = CMP_W'(pulse_r) + CMP_W'(1);
    if (!ctrl.started) begin
      firing_nxt = 1'b0;
      gate_nxt   = 1'b0;
      if (ctrl.clr_arm) begin
        armed_nxt = 1'b0;
      end
    end else if (firing_r) begin
      if (pls_inc > CMP_W'(pulse_width)) begin
        firing_nxt = 1'b0;
        gate_nxt   = 1'b0;
        pulse_nxt  = '0;
      end else begin
        pulse_nxt = pls_inc[COUNT_WIDTH-1:0];
      end
    end else begin
      pulse_nxt = '0;
      if (armed_m) begin
        if (dly_inc > CMP_W'(fire_delay)) begin
          firing_nxt = 1'b1;
          armed_nxt  = 1'b0;
          delay_nxt  = '0;
          gate_nxt   = ~ctrl.brake_cut;
        end else begin
          delay_nxt = dly_inc[COUNT_WIDTH-1:0];
        end
      end else begin
        gate_nxt  = 1'b0;
        delay_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      firing_r <= 1'b0;
      gate_r   <= 1'b0;
      delay_r  <= '0;
      pulse_r  <= '0;
    end else if (ctrl.step) begin
      armed_r  <= armed_nxt;
      firing_r <= firing_nxt;
      gate_r   <= gate_nxt;
      delay_r  <= delay_nxt;
      pulse_r  <= pulse_nxt;
    end
  end

  assign stat.armed   = armed_r;
  assign stat.firing  = firing_r;
  assign stat.gate_on = gate_r;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tfpg_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 92;
  localparam int DIR_ROWS    = 26;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0] gate_mask;
    logic                running;
  } gate_state_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [REG_W-1:0]       data;
    logic [NUM_CHAN-1:0]    arm;
    logic                   brk;
    int                     reps;
    bit                     typed;
    gate_state_t            want;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tfpg_in_if  in_chan ();
  tfpg_out_if out_chan ();
  tfpg_cfg_if cfg_chan ();

  thyristor_firing_pulse_gen dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #2 clk = ~clk;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int mismatches   = 0;

  gate_state_t gate_expect_q [$];
  gate_state_t gate_want;

  logic [REG_W-1:0]           fire_delay_r  = '0;
  logic [REG_W-1:0]           pulse_width_r = '0;
  logic                       started_r     = 1'b0;
  logic [START_W-1:0]         start_cnt_r   = '0;
  logic [NUM_CHAN-1:0]        armed_r       = '0;
  logic [NUM_CHAN-1:0]        firing_r      = '0;
  logic [NUM_CHAN-1:0]        gate_r        = '0;
  logic [COUNT_WIDTH_DEF-1:0] delay_cnt_r [NUM_CHAN] = '{default: '0};
  logic [COUNT_WIDTH_DEF-1:0] pulse_cnt_r [NUM_CHAN] = '{default: '0};

  plan_row_t dir_plan [DIR_ROWS] = '{
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h00, 1'b0, 1,      1'b1, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h3F, 1'b1, 1,      1'b1, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h3E, 1'b0, 1,      1'b1, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h01, 1'b0, 29,     1'b1, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h3E, 1'b0, 1,      1'b1, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h01, 1'b0, 1,      1'b1, '{6'h00, 1'b1}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h00, 1'b0, 1,      1'b1, '{6'h00, 1'b1}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h3F, 1'b0, 1,      1'b1, '{6'h3F, 1'b1}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h00, 1'b0, 1,      1'b1, '{6'h00, 1'b1}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h3F, 1'b1, 1,      1'b1, '{6'h1D, 1'b1}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h00, 1'b0, 1,      1'b1, '{6'h00, 1'b1}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h22, 1'b1, 1,      1'b0, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h22, 1'b0, 3,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_FIRE_DELAY,  16'h0003, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_PULSE_WIDTH, 16'h0002, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h15, 1'b0, 1,      1'b0, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h00, 1'b1, 8,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_SPARE_A,     16'hFFFF, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_SPARE_B,     16'h1234, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h2A, 1'b1, 10,     1'b0, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h00, 1'b0, 8,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_FIRE_DELAY,  16'hFFFE, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_PULSE_WIDTH, 16'hFFFE, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}},
    '{ROW_TICK, REG_FIRE_DELAY,  16'h0000, 6'h3F, 1'b0, 6,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_FIRE_DELAY,  16'hFFFF, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}},
    '{ROW_CFG,  REG_PULSE_WIDTH, 16'hFFFF, 6'h00, 1'b0, 0,      1'b0, '{6'h00, 1'b0}}
  };

  function automatic gate_state_t fire_tick(input logic [NUM_CHAN-1:0] arm, input logic brk);
    logic [COUNT_WIDTH_DEF:0] nxt;
    gate_state_t              res;
    armed_r = armed_r | arm;
    if (!started_r) begin
      firing_r = '0;
      gate_r   = '0;
      if (armed_r[0]) begin
        armed_r = '0;
        if (int'(start_cnt_r) + 1 > START_EVENTS_DEF) begin
          start_cnt_r = '0;
          started_r   = 1'b1;
        end else begin
          start_cnt_r = start_cnt_r + 1'b1;
        end
      end
    end else begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (firing_r[c]) begin
          nxt = {1'b0, pulse_cnt_r[c]} + 1'b1;
          if (nxt > {1'b0, pulse_width_r}) begin
            firing_r[c]    = 1'b0;
            gate_r[c]      = 1'b0;
            pulse_cnt_r[c] = '0;
          end else begin
            pulse_cnt_r[c] = nxt[COUNT_WIDTH_DEF-1:0];
          end
        end else begin
          pulse_cnt_r[c] = '0;
          if (armed_r[c]) begin
            nxt = {1'b0, delay_cnt_r[c]} + 1'b1;
            if (nxt > {1'b0, fire_delay_r}) begin
              firing_r[c]    = 1'b1;
              armed_r[c]     = 1'b0;
              delay_cnt_r[c] = '0;
              gate_r[c]      = !(brk && BRAKE_LOW_MASK[c]);
            end else begin
              delay_cnt_r[c] = nxt[COUNT_WIDTH_DEF-1:0];
            end
          end else begin
            gate_r[c]      = 1'b0;
            delay_cnt_r[c] = '0;
          end
        end
      end
    end
    res.gate_mask = gate_r;
    res.running   = started_r;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_tick(input logic [NUM_CHAN-1:0] arm, input logic brk, input bit typed,
                           input gate_state_t want);
    gate_state_t pred;
    cfg_chan.valid <= 1'b0;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_chan.valid    <= 1'b1;
    in_chan.arm_mask <= arm;
    in_chan.brake    <= brk;
    do @(posedge clk); while (!in_chan.ready);
    pred = fire_tick(arm, brk);
    gate_expect_q.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
    in_chan.valid <= 1'b0;
    while (gate_expect_q.size() != 0) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    if (idx == REG_FIRE_DELAY) begin
      fire_delay_r = val;
    end else if (idx == REG_PULSE_WIDTH) begin
      pulse_width_r = val;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (gate_expect_q.size() == 0) begin
        report_mismatch("unexpected item, gate_mask", out_chan.gate_mask, 0);
      end else begin
        gate_want = gate_expect_q.pop_front();
        if (out_chan.gate_mask !== gate_want.gate_mask)
          report_mismatch("gate_mask", out_chan.gate_mask, gate_want.gate_mask);
        if (out_chan.running !== gate_want.running)
          report_mismatch("running", out_chan.running, gate_want.running);
      end
    end
    out_chan.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  initial begin
    plan_row_t           row;
    logic [NUM_CHAN-1:0] arm;
    logic                brk;
    logic [REG_W-1:0]    fd;
    logic [REG_W-1:0]    pw;
    int                  sel;
    in_chan.valid    = 1'b0;
    in_chan.arm_mask = '0;
    in_chan.brake    = 1'b0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.index   = REG_FIRE_DELAY;
    cfg_chan.data    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_plan[i]) begin
      row = dir_plan[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.data);
      end else begin
        for (int r = 0; r < row.reps; r++) send_tick(row.arm, row.brk, row.typed, row.want);
      end
    end
    send_tick(6'h00, 1'b0, 1'b0, '0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph * 3 / RAND_PHASES)
        0: begin
          in_idle_pct  = 11;
          out_idle_pct = 76;
        end
        1: begin
          in_idle_pct  = 76;
          out_idle_pct = 11;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      sel = $urandom_range(0, 15);
      fd  = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFE : (sel == 2) ? 16'hFFFF :
            REG_W'($urandom_range(0, 12));
      sel = $urandom_range(0, 15);
      pw  = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFE : (sel == 2) ? 16'hFFFF :
            REG_W'($urandom_range(0, 8));
      write_reg(REG_FIRE_DELAY, fd);
      write_reg(REG_PULSE_WIDTH, pw);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, REG_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0) begin
          arm = NUM_CHAN'($urandom);
        end else begin
          for (int b = 0; b < NUM_CHAN; b++) arm[b] = ($urandom_range(0, 7) == 0);
        end
        brk = ($urandom_range(0, 3) == 0);
        send_tick(arm, brk, 1'b0, '0);
      end
    end

    in_chan.valid <= 1'b0;
    while (gate_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[thyristor_firing_pulse_gen] OK");
    end else begin
      $display("[thyristor_firing_pulse_gen] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[thyristor_firing_pulse_gen] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tfpg_pkg.sv
hdl/tfpg_in_if.sv
hdl/tfpg_out_if.sv
hdl/tfpg_cfg_if.sv
hdl/tfpg_chan.sv
hdl/thyristor_firing_pulse_gen.sv
tb/tb_top.sv
